[rtl/core/ntp_pkg.sv]
// ----------------------------------------------------------------------------
// ntp_pkg
// Shared types and constants of the numeric token parser: word formats,
// character codes, token classes, result kinds and overflow limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ntp_pkg;

    // Integer result width; fixed by the result word format.
    localparam int VALUE_BITS = 32;

    // Default depth of the token queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result kinds
    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_BIGNUM  = 3'd1;
    localparam logic [2:0] KIND_REAL    = 3'd2;
    localparam logic [2:0] KIND_NAN     = 3'd3;
    localparam logic [2:0] KIND_REAL_ND = 3'd4;

    // Character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Character classes
    localparam logic [2:0] CC_OTHER = 3'd0;
    localparam logic [2:0] CC_HASH  = 3'd1;
    localparam logic [2:0] CC_PLUS  = 3'd2;
    localparam logic [2:0] CC_MINUS = 3'd3;
    localparam logic [2:0] CC_POINT = 3'd4;
    localparam logic [2:0] CC_EXPO  = 3'd5;

    // Prefix letters (case folded)
    localparam logic [2:0] PFX_NONE = 3'd0;
    localparam logic [2:0] PFX_B    = 3'd1;
    localparam logic [2:0] PFX_O    = 3'd2;
    localparam logic [2:0] PFX_D    = 3'd3;
    localparam logic [2:0] PFX_X    = 3'd4;
    localparam logic [2:0] PFX_E    = 3'd5;
    localparam logic [2:0] PFX_I    = 3'd6;

    // Digit value meaning "not a digit"
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Radix values
    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    // Accumulator limits: largest magnitude for positive and negative values
    localparam logic [VALUE_BITS-1:0] LIM_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] LIM_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Overflow thresholds: quotient and remainder of each limit by each radix
    localparam logic [VALUE_BITS-1:0] QP_BIN = LIM_POS / 2;
    localparam logic [VALUE_BITS-1:0] QP_OCT = LIM_POS / 8;
    localparam logic [VALUE_BITS-1:0] QP_DEC = LIM_POS / 10;
    localparam logic [VALUE_BITS-1:0] QP_HEX = LIM_POS / 16;
    localparam logic [VALUE_BITS-1:0] QN_BIN = LIM_NEG / 2;
    localparam logic [VALUE_BITS-1:0] QN_OCT = LIM_NEG / 8;
    localparam logic [VALUE_BITS-1:0] QN_DEC = LIM_NEG / 10;
    localparam logic [VALUE_BITS-1:0] QN_HEX = LIM_NEG / 16;
    localparam logic [4:0] RP_BIN = 5'(LIM_POS % 2);
    localparam logic [4:0] RP_OCT = 5'(LIM_POS % 8);
    localparam logic [4:0] RP_DEC = 5'(LIM_POS % 10);
    localparam logic [4:0] RP_HEX = 5'(LIM_POS % 16);
    localparam logic [4:0] RN_BIN = 5'(LIM_NEG % 2);
    localparam logic [4:0] RN_OCT = 5'(LIM_NEG % 8);
    localparam logic [4:0] RN_DEC = 5'(LIM_NEG % 10);
    localparam logic [4:0] RN_HEX = 5'(LIM_NEG % 16);

    // Input word: one character of a token
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    // Result word: one classified token
    typedef struct packed {
        logic [2:0]                   kind;
        logic signed [VALUE_BITS-1:0] value;
        logic                         exact_req;
        logic                         inexact_req;
    } out_word_t;

    // Classified character between front and back
    typedef struct packed {
        logic [2:0] cls;
        logic [2:0] pfx;
        logic [4:0] digit;
        logic       last;
    } tok_t;

endpackage

`default_nettype wire

[rtl/core/ntp_front.sv]
// ----------------------------------------------------------------------------
// ntp_front
// Character classifier: decodes one input word into class, prefix letter and
// digit value for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_front
(
    input  wire ntp_pkg::in_word_t chr,
    output ntp_pkg::tok_t          tok
);

    logic [7:0] folded;

    assign folded = chr.ch | ntp_pkg::CASE_BIT;

    always_comb
    begin
        tok.last = chr.last;

        case (chr.ch)
            ntp_pkg::CH_HASH:  tok.cls = ntp_pkg::CC_HASH;
            ntp_pkg::CH_PLUS:  tok.cls = ntp_pkg::CC_PLUS;
            ntp_pkg::CH_MINUS: tok.cls = ntp_pkg::CC_MINUS;
            ntp_pkg::CH_POINT: tok.cls = ntp_pkg::CC_POINT;
            ntp_pkg::CH_LE:    tok.cls = ntp_pkg::CC_EXPO;
            ntp_pkg::CH_UE:    tok.cls = ntp_pkg::CC_EXPO;
            default:           tok.cls = ntp_pkg::CC_OTHER;
        endcase

        case (folded)
            ntp_pkg::CH_LB: tok.pfx = ntp_pkg::PFX_B;
            ntp_pkg::CH_LO: tok.pfx = ntp_pkg::PFX_O;
            ntp_pkg::CH_LD: tok.pfx = ntp_pkg::PFX_D;
            ntp_pkg::CH_LX: tok.pfx = ntp_pkg::PFX_X;
            ntp_pkg::CH_LE: tok.pfx = ntp_pkg::PFX_E;
            ntp_pkg::CH_LI: tok.pfx = ntp_pkg::PFX_I;
            default:        tok.pfx = ntp_pkg::PFX_NONE;
        endcase

        if (chr.ch inside {[ntp_pkg::CH_0:ntp_pkg::CH_9]})
        begin
            tok.digit = 5'(chr.ch - ntp_pkg::CH_0);
        end
        else if (chr.ch inside {[ntp_pkg::CH_LA:ntp_pkg::CH_LF]})
        begin
            tok.digit = 5'(chr.ch - ntp_pkg::CH_LA + 8'd10);
        end
        else if (chr.ch inside {[ntp_pkg::CH_UA:ntp_pkg::CH_UF]})
        begin
            tok.digit = 5'(chr.ch - ntp_pkg::CH_UA + 8'd10);
        end
        else
        begin
            tok.digit = ntp_pkg::DIGIT_NONE;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ntp_queue.sv]
// ----------------------------------------------------------------------------
// ntp_queue
// Small token queue between the classifier and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_queue
#(
    parameter int DEPTH = ntp_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr_en,
    input  wire ntp_pkg::tok_t wr_tok,
    output logic               full,
    input  wire                rd_en,
    output ntp_pkg::tok_t      rd_tok,
    output logic               avail
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ntp_pkg::tok_t   slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign full   = (cnt_reg == FULL_CNT);
    assign avail  = (cnt_reg != '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && avail;
    assign rd_tok = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ntp_back.sv]
// ----------------------------------------------------------------------------
// ntp_back
// Token parser: prefix/sign/point/exponent checks, radix accumulation with
// overflow detection, and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_back
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    tok_avail,
    input  wire ntp_pkg::tok_t     tok,
    output logic                   tok_take,
    output logic                   empty,
    input  wire                    pop,
    output ntp_pkg::out_word_t     res
);

    localparam int VB = ntp_pkg::VALUE_BITS;

    // parse state
    logic          in_prefix_reg, in_prefix_next;
    logic          hash_reg, hash_next;
    logic [4:0]    radix_reg, radix_next;
    logic          got_radix_reg, got_radix_next;
    logic          exact_reg, exact_next;
    logic          inexact_reg, inexact_next;
    logic          neg_reg, neg_next;
    logic          point_reg, point_next;
    logic          expo_reg, expo_next;
    logic          after_e_reg, after_e_next;
    logic          mdigit_reg, mdigit_next;
    logic          edigit_reg, edigit_next;
    logic          bad_reg, bad_next;
    logic          ovf_reg, ovf_next;
    logic          started_reg, started_next;
    logic [VB-1:0] accum_reg, accum_next;

    // state after this word, before the end-of-token clear
    logic          u_in_prefix, u_hash, u_got_radix, u_exact, u_inexact;
    logic [4:0]    u_radix;
    logic          u_neg, u_point, u_expo, u_after_e, u_mdigit, u_edigit;
    logic          u_bad, u_ovf, u_started;
    logic [VB-1:0] u_accum;

    logic          is_sign;
    logic [VB-1:0] max_q;
    logic [4:0]    max_r;
    logic          ovf_hit;
    logic [VB-1:0] scaled;

    ntp_pkg::out_word_t res_reg, res_next;
    logic               res_valid_reg;
    logic               load_res;

    assign empty    = !res_valid_reg;
    assign res      = res_reg;
    // a token end needs the result register free, or freed this cycle
    assign tok_take = tok_avail && (!tok.last || !res_valid_reg || pop);
    assign load_res = tok_take && tok.last;
    assign is_sign  = (tok.cls == ntp_pkg::CC_PLUS) || (tok.cls == ntp_pkg::CC_MINUS);

    // overflow thresholds for the current radix and sign
    always_comb
    begin
        case (radix_reg)
            ntp_pkg::RADIX_BIN:
            begin
                max_q = neg_reg ? ntp_pkg::QN_BIN : ntp_pkg::QP_BIN;
                max_r = neg_reg ? ntp_pkg::RN_BIN : ntp_pkg::RP_BIN;
                scaled = accum_reg << 1;
            end
            ntp_pkg::RADIX_OCT:
            begin
                max_q = neg_reg ? ntp_pkg::QN_OCT : ntp_pkg::QP_OCT;
                max_r = neg_reg ? ntp_pkg::RN_OCT : ntp_pkg::RP_OCT;
                scaled = accum_reg << 3;
            end
            ntp_pkg::RADIX_DEC:
            begin
                max_q = neg_reg ? ntp_pkg::QN_DEC : ntp_pkg::QP_DEC;
                max_r = neg_reg ? ntp_pkg::RN_DEC : ntp_pkg::RP_DEC;
                scaled = (accum_reg << 3) + (accum_reg << 1);
            end
            default:
            begin
                max_q = neg_reg ? ntp_pkg::QN_HEX : ntp_pkg::QP_HEX;
                max_r = neg_reg ? ntp_pkg::RN_HEX : ntp_pkg::RP_HEX;
                scaled = accum_reg << 4;
            end
        endcase
    end

    assign ovf_hit = (accum_reg > max_q) || ((accum_reg == max_q) && (tok.digit > max_r));

    // per-word state update
    always_comb
    begin
        u_in_prefix = in_prefix_reg;
        u_hash      = hash_reg;
        u_radix     = radix_reg;
        u_got_radix = got_radix_reg;
        u_exact     = exact_reg;
        u_inexact   = inexact_reg;
        u_neg       = neg_reg;
        u_point     = point_reg;
        u_expo      = expo_reg;
        u_after_e   = after_e_reg;
        u_mdigit    = mdigit_reg;
        u_edigit    = edigit_reg;
        u_bad       = bad_reg;
        u_ovf       = ovf_reg;
        u_started   = started_reg;
        u_accum     = accum_reg;

        if (hash_reg)
        begin
            // letter after '#'
            u_hash = 1'b0;
            case (tok.pfx)
                ntp_pkg::PFX_B, ntp_pkg::PFX_O, ntp_pkg::PFX_D, ntp_pkg::PFX_X:
                begin
                    if (got_radix_reg)
                    begin
                        u_bad = 1'b1;
                    end
                    else
                    begin
                        u_got_radix = 1'b1;
                        case (tok.pfx)
                            ntp_pkg::PFX_B: u_radix = ntp_pkg::RADIX_BIN;
                            ntp_pkg::PFX_O: u_radix = ntp_pkg::RADIX_OCT;
                            ntp_pkg::PFX_D: u_radix = ntp_pkg::RADIX_DEC;
                            default:        u_radix = ntp_pkg::RADIX_HEX;
                        endcase
                    end
                end
                ntp_pkg::PFX_E:
                begin
                    if (exact_reg || inexact_reg)
                    begin
                        u_bad = 1'b1;
                    end
                    u_exact = 1'b1;
                end
                ntp_pkg::PFX_I:
                begin
                    if (exact_reg || inexact_reg)
                    begin
                        u_bad = 1'b1;
                    end
                    u_inexact = 1'b1;
                end
                default:
                begin
                    u_bad = 1'b1;
                end
            endcase
        end
        else if (in_prefix_reg && (tok.cls == ntp_pkg::CC_HASH))
        begin
            u_hash = 1'b1;
        end
        else
        begin
            u_in_prefix = 1'b0;
            u_started   = 1'b1;
            if (!started_reg && is_sign)
            begin
                // leading sign
                u_neg = (tok.cls == ntp_pkg::CC_MINUS);
            end
            else if (after_e_reg && is_sign)
            begin
                // exponent sign
                u_after_e = 1'b0;
            end
            else
            begin
                u_after_e = 1'b0;
                if (tok.cls == ntp_pkg::CC_POINT)
                begin
                    if (expo_reg || point_reg)
                    begin
                        u_bad = 1'b1;
                    end
                    u_point = 1'b1;
                end
                else if ((radix_reg != ntp_pkg::RADIX_HEX) && (tok.cls == ntp_pkg::CC_EXPO))
                begin
                    if (expo_reg)
                    begin
                        u_bad = 1'b1;
                    end
                    u_expo    = 1'b1;
                    u_after_e = 1'b1;
                end
                else if (tok.digit >= radix_reg)
                begin
                    u_bad = 1'b1;
                end
                else if (expo_reg)
                begin
                    u_edigit = 1'b1;
                end
                else
                begin
                    u_mdigit = 1'b1;
                    if (!(point_reg || ovf_reg))
                    begin
                        if (ovf_hit)
                        begin
                            u_ovf = 1'b1;
                        end
                        else
                        begin
                            u_accum = scaled + VB'(tok.digit);
                        end
                    end
                end
            end
        end
    end

    // end-of-token classification
    always_comb
    begin
        logic bad_f;
        bad_f = u_bad || u_hash;
        res_next.exact_req   = u_exact;
        res_next.inexact_req = u_inexact;
        res_next.value       = '0;
        if (bad_f || !u_mdigit || (u_expo && !u_edigit))
        begin
            res_next.kind = ntp_pkg::KIND_NAN;
        end
        else if (u_point || u_expo)
        begin
            res_next.kind = (u_radix != ntp_pkg::RADIX_DEC) ? ntp_pkg::KIND_REAL_ND
                                                            : ntp_pkg::KIND_REAL;
        end
        else if (u_ovf)
        begin
            res_next.kind = ntp_pkg::KIND_BIGNUM;
        end
        else
        begin
            res_next.kind  = ntp_pkg::KIND_INT;
            res_next.value = u_neg ? -u_accum : u_accum;
        end
    end

    // commit: a token end returns the parser to its reset state
    always_comb
    begin
        if (tok.last)
        begin
            in_prefix_next = 1'b1;
            hash_next      = 1'b0;
            radix_next     = ntp_pkg::RADIX_DEC;
            got_radix_next = 1'b0;
            exact_next     = 1'b0;
            inexact_next   = 1'b0;
            neg_next       = 1'b0;
            point_next     = 1'b0;
            expo_next      = 1'b0;
            after_e_next   = 1'b0;
            mdigit_next    = 1'b0;
            edigit_next    = 1'b0;
            bad_next       = 1'b0;
            ovf_next       = 1'b0;
            started_next   = 1'b0;
            accum_next     = '0;
        end
        else
        begin
            in_prefix_next = u_in_prefix;
            hash_next      = u_hash;
            radix_next     = u_radix;
            got_radix_next = u_got_radix;
            exact_next     = u_exact;
            inexact_next   = u_inexact;
            neg_next       = u_neg;
            point_next     = u_point;
            expo_next      = u_expo;
            after_e_next   = u_after_e;
            mdigit_next    = u_mdigit;
            edigit_next    = u_edigit;
            bad_next       = u_bad;
            ovf_next       = u_ovf;
            started_next   = u_started;
            accum_next     = u_accum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prefix_reg <= 1'b1;
            hash_reg      <= 1'b0;
            radix_reg     <= ntp_pkg::RADIX_DEC;
            got_radix_reg <= 1'b0;
            exact_reg     <= 1'b0;
            inexact_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            point_reg     <= 1'b0;
            expo_reg      <= 1'b0;
            after_e_reg   <= 1'b0;
            mdigit_reg    <= 1'b0;
            edigit_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            started_reg   <= 1'b0;
            accum_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_take)
            begin
                in_prefix_reg <= in_prefix_next;
                hash_reg      <= hash_next;
                radix_reg     <= radix_next;
                got_radix_reg <= got_radix_next;
                exact_reg     <= exact_next;
                inexact_reg   <= inexact_next;
                neg_reg       <= neg_next;
                point_reg     <= point_next;
                expo_reg      <= expo_next;
                after_e_reg   <= after_e_next;
                mdigit_reg    <= mdigit_next;
                edigit_reg    <= edigit_next;
                bad_reg       <= bad_next;
                ovf_reg       <= ovf_next;
                started_reg   <= started_next;
                accum_reg     <= accum_next;
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/numeric_token_parser_core.sv]
// ----------------------------------------------------------------------------
// numeric_token_parser_core
// Numeric literal classifier: reads a token one character word at a time and
// reports kind, integer value and exactness prefixes on the token's last word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake       Word         Fields
//   input     push / full     chr          ch[7:0], last
//   result    empty / pop     res          kind[2:0], value[31:0] signed,
//                                          exact_req, inexact_req
//
// One character word is accepted per cycle while the queue is not full; the
// classifier is combinational ahead of the token queue, and the back end
// retires one queued word per cycle. With the queue otherwise empty, the
// token's last word is written into the queue and then parsed from the queue
// head into the result register, whose word shows on res.
// The back end stalls only on a last word while an untaken result is held;
// the queue (QUEUE_DEPTH words) keeps the input side open meanwhile.
// Reset clears the queue and the parse state and marks the result register
// empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_token_parser_core
#(
    parameter int QUEUE_DEPTH = ntp_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    // input channel
    input  wire                     push,
    output logic                    full,
    input  wire ntp_pkg::in_word_t  chr,
    // result channel
    output logic                    empty,
    input  wire                     pop,
    output ntp_pkg::out_word_t      res
);

    ntp_pkg::tok_t cls_tok;   // classified character from the front end
    ntp_pkg::tok_t head_tok;  // oldest queued token
    logic          head_avail;
    logic          head_take;

    // front: character classification
    ntp_front u_front
    (
        .chr (chr),
        .tok (cls_tok)
    );

    // decoupling queue; full here is the input channel's full
    ntp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_tok (cls_tok),
        .full   (full),
        .rd_en  (head_take),
        .rd_tok (head_tok),
        .avail  (head_avail)
    );

    // back: parse state, accumulation and result register
    ntp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_avail (head_avail),
        .tok       (head_tok),
        .tok_take  (head_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

endmodule

`default_nettype wire

[rtl/core/ntp_checker.sv]
// ----------------------------------------------------------------------------
// ntp_checker
// Port-level checks of the numeric token parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_checker
(
    input wire                     clk,
    input wire                     rst_n,
    input wire                     full,
    input wire                     empty,
    input wire                     pop,
    input wire ntp_pkg::out_word_t res
);

    // handshake flags are always driven
    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("full or empty unknown");

    // kind codes stop at real-not-decimal
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (res.kind <= ntp_pkg::KIND_REAL_ND))
        else $error("result kind out of range");

    // only integers carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res.kind != ntp_pkg::KIND_INT)) |-> (res.value == '0))
        else $error("nonzero value on non-integer result");

    // both exactness prefixes can only come with an invalid token
    a_exact_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res.exact_req && res.inexact_req) |-> (res.kind == ntp_pkg::KIND_NAN))
        else $error("conflicting exactness prefixes not flagged");

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("result word changed while waiting");

endmodule

bind numeric_token_parser_core ntp_checker u_ntp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .res   (res)
);

`default_nettype wire
